/* rtl/rcat_pkg.sv */
// Shared types and constants for the reference-count aging key table.
`default_nettype none

package rcat_pkg;

	// Fixed field widths of the stream and configuration ports.
	localparam int KEY_W     = 32;
	localparam int MARK_W    = 7;
	localparam int CNT_OUT_W = 7;
	localparam int STATUS_W  = 3;
	localparam int CFG_IDX_W = 1;
	localparam int OUT_TDATA_W = 16;

	// Reset values of the watermark registers.
	localparam logic [MARK_W-1:0] HIGH_MARK_RST = 7'd64;
	localparam logic [MARK_W-1:0] LOW_MARK_RST  = 7'd32;

	// Operation codes carried on the input side.
	localparam logic OP_REF   = 1'b0;
	localparam logic OP_CLEAN = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HIGH_MARK = 1'b0,
		CFG_LOW_MARK  = 1'b1
	} rcat_cfg_idx_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		RES_INSERTED = 3'd0,
		RES_HIT      = 3'd1,
		RES_REJECTED = 3'd2,
		RES_CLEANED  = 3'd3,
		RES_SKIPPED  = 3'd4
	} rcat_status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear;
		logic load;
		logic scan;
		logic finish;
	} rcat_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clr_last;
		logic hit;
		logic scan_end;
		logic skip;
	} rcat_sts_t;

endpackage

`default_nettype wire

/* rtl/rcat_ctrl.sv */
// Controller state machine that sequences clearing, scanning and result hand-off.
`default_nettype none

module rcat_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic              out_free,
	input  wire rcat_pkg::rcat_sts_t sts,
	output rcat_pkg::rcat_cmd_t    cmd,
	output logic                   in_ready
);
	import rcat_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR  = 4'b0001,
		S_IDLE   = 4'b0010,
		S_SCAN   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	// Next-state logic.
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			S_CLEAR: begin
				if (sts.clr_last) state_nxt = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) state_nxt = S_SCAN;
			end
			S_SCAN: begin
				if (sts.hit || sts.scan_end || sts.skip) state_nxt = S_FINISH;
			end
			S_FINISH: begin
				if (out_free) state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_CLEAR;
			end
		endcase
	end

	// State register; reset starts the clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Commands decoded from the state.
	assign in_ready   = (state_q == S_IDLE);
	assign cmd.clear  = (state_q == S_CLEAR);
	assign cmd.load   = (state_q == S_IDLE) && in_valid;
	assign cmd.scan   = (state_q == S_SCAN);
	assign cmd.finish = (state_q == S_FINISH) && out_free;

	// A scan that ends always lands in the finish state.
	a_scan_to_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan && (sts.hit || sts.scan_end)) |=> (state_q == S_FINISH))
		else $error("scan end did not move to finish");

	// An accepted item is followed by a cycle without acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> !in_ready)
		else $error("second item accepted while busy");

	// Clearing is only ever left for idle.
	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear && sts.clr_last) |=> (state_q == S_IDLE))
		else $error("clearing pass exited incorrectly");

endmodule

`default_nettype wire

/* rtl/rcat_datapath.sv */
// Datapath with the entry memory, scan address, counters and result formation.
`default_nettype none

module rcat_datapath #(
	parameter int CAPACITY = 64,
	parameter int REF_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire rcat_pkg::rcat_cmd_t                 cmd,
	output rcat_pkg::rcat_sts_t                      sts,
	input  wire logic                                in_opcode,
	input  wire logic [rcat_pkg::KEY_W-1:0]          in_key,
	input  wire logic                                in_check,
	input  wire logic [rcat_pkg::MARK_W-1:0]         high_mark,
	input  wire logic [rcat_pkg::MARK_W-1:0]         low_mark,
	output rcat_pkg::rcat_status_t                   res_status,
	output logic [rcat_pkg::CNT_OUT_W-1:0]           res_count,
	output logic [rcat_pkg::CNT_OUT_W-1:0]           res_evicted
);
	import rcat_pkg::*;

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (CW > MARK_W) ? CW : MARK_W;
	localparam int WW = 1 + REF_BITS + KEY_W;
	localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

	// Entry word: valid on top, then the counter, then the key.
	logic [WW-1:0] mem [CAPACITY];

	logic [AW-1:0]       addr_q;
	logic [AW-1:0]       idx_s1;
	logic [AW-1:0]       free_q;
	logic [WW-1:0]       rd_data_s1;
	logic                rd_vld_s1;
	logic                issued_q;
	logic                op_q;
	logic                skip_q;
	logic                hit_q;
	logic                free_fnd_q;
	logic [KEY_W-1:0]    key_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       evict_q;

	logic                e_valid;
	logic [REF_BITS-1:0] e_refs;
	logic [KEY_W-1:0]    e_key;
	logic [REF_BITS-1:0] refs_inc;
	logic                proc;
	logic                hit_now;
	logic                evict_now;
	logic                free_now;
	logic                rd_en;
	logic                ins_ok;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [WW-1:0]       wr_data;
	logic [CW-1:0]       count_new;

	// Fields of the entry read in the previous cycle.
	assign e_valid  = rd_data_s1[WW-1];
	assign e_refs   = rd_data_s1[KEY_W +: REF_BITS];
	assign e_key    = rd_data_s1[KEY_W-1:0];
	assign refs_inc = (e_refs == {REF_BITS{1'b1}}) ? e_refs : e_refs + REF_BITS'(1);

	// Scan qualifiers.
	assign rd_en     = cmd.scan && !issued_q && !skip_q;
	assign proc      = cmd.scan && rd_vld_s1 && !skip_q;
	assign hit_now   = proc && (op_q == OP_REF) && e_valid && (e_key == key_q);
	assign free_now  = proc && (op_q == OP_REF) && !e_valid && !free_fnd_q;
	assign evict_now = proc && (op_q == OP_CLEAN) && e_valid && (e_refs <= REF_BITS'(1));
	assign ins_ok    = (op_q == OP_REF) && !skip_q && !hit_q && free_fnd_q &&
	                   (MW'(count_q) < MW'(high_mark));

	// Single write port: clearing pass, scan write-back, or insert.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = addr_q;
		wr_data = '0;
		if (cmd.clear) begin
			wr_en = 1'b1;
		end else if (proc) begin
			wr_addr = idx_s1;
			if (op_q == OP_REF) begin
				if (hit_now) begin
					wr_en   = 1'b1;
					wr_data = {1'b1, refs_inc, e_key};
				end
			end else if (e_valid) begin
				wr_en = 1'b1;
				if (!evict_now) begin
					wr_data = {1'b1, e_refs - REF_BITS'(1), e_key};
				end
			end
		end else if (cmd.finish && ins_ok) begin
			wr_en   = 1'b1;
			wr_addr = free_q;
			wr_data = {1'b1, REF_BITS'(1), key_q};
		end
	end

	// Entry memory with registered read data.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[addr_q];
		end
	end

	// Result of the current item.
	always_comb begin
		if (skip_q) begin
			res_status = RES_SKIPPED;
			count_new  = count_q;
		end else if (op_q == OP_CLEAN) begin
			res_status = RES_CLEANED;
			count_new  = count_q - evict_q;
		end else if (hit_q) begin
			res_status = RES_HIT;
			count_new  = count_q;
		end else if (ins_ok) begin
			res_status = RES_INSERTED;
			count_new  = count_q + CW'(1);
		end else begin
			res_status = RES_REJECTED;
			count_new  = count_q;
		end
	end

	assign res_count   = CNT_OUT_W'(count_new);
	assign res_evicted = CNT_OUT_W'(evict_q);

	// Control registers of the scan.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q     <= '0;
			issued_q   <= 1'b0;
			rd_vld_s1  <= 1'b0;
			op_q       <= OP_REF;
			skip_q     <= 1'b0;
			hit_q      <= 1'b0;
			free_fnd_q <= 1'b0;
			evict_q    <= '0;
			count_q    <= '0;
		end else begin
			if (cmd.clear) begin
				addr_q <= (addr_q == LAST_ADDR) ? '0 : addr_q + AW'(1);
			end
			if (cmd.load) begin
				addr_q     <= '0;
				issued_q   <= 1'b0;
				rd_vld_s1  <= 1'b0;
				op_q       <= in_opcode;
				skip_q     <= (in_opcode == OP_CLEAN) && in_check &&
				              (MW'(count_q) <= MW'(low_mark));
				hit_q      <= 1'b0;
				free_fnd_q <= 1'b0;
				evict_q    <= '0;
			end
			if (cmd.scan) begin
				rd_vld_s1 <= rd_en;
				if (rd_en) begin
					addr_q <= (addr_q == LAST_ADDR) ? '0 : addr_q + AW'(1);
					if (addr_q == LAST_ADDR) issued_q <= 1'b1;
				end
				if (hit_now) hit_q <= 1'b1;
				if (free_now) free_fnd_q <= 1'b1;
				if (evict_now) evict_q <= evict_q + CW'(1);
			end
			if (cmd.finish) begin
				count_q <= count_new;
			end
		end
	end

	// Payload registers of the scan.
	always_ff @(posedge clk) begin
		if (cmd.load) key_q <= in_key;
		if (rd_en) idx_s1 <= addr_q;
		if (free_now) free_q <= idx_s1;
	end

	assign sts.clr_last = (addr_q == LAST_ADDR);
	assign sts.hit      = hit_now;
	assign sts.scan_end = proc && (idx_s1 == LAST_ADDR);
	assign sts.skip     = skip_q;

	// Evictions cannot outnumber the valid entries.
	a_evict_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (evict_q <= count_q))
		else $error("eviction count exceeds entry count");

	// An insert only happens with room left in the table.
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && ins_ok) |-> (count_q < CW'(CAPACITY)))
		else $error("insert into a full table");

	// A hit ends the reference scan, so no second hit follows.
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		hit_now |=> !hit_now)
		else $error("two hits in one scan");

endmodule

`default_nettype wire

/* rtl/refcount_aging_key_table.sv */
// Top level of the reference-count aging key table.
//
// Usage: items enter on the s_ stream (s_tdata = lookup key, s_tuser = opcode and
// check flag); each item yields exactly one result beat on the m_ stream (m_tuser =
// status, m_tdata = entry count and evicted count). The cfg_ channel writes the high
// and low marks; cfg_ready is always high and writes are meant for idle periods.
// One item is worked on at a time. A reference scans the entry memory one entry a
// cycle until it hits or reaches the last entry; a clean always walks all CAPACITY
// entries, and a skipped clean reads none. The walk is set by the single read port
// of the entry memory. After reset the block runs a clearing pass over all CAPACITY
// entries with s_tready low. The result sits in an output register: the next item
// is accepted while it waits, and only the hand-off of the following result waits
// for m_tready.
`default_nettype none

module refcount_aging_key_table #(
	parameter int CAPACITY = 64,
	parameter int REF_BITS = 16
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Input stream.
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [rcat_pkg::KEY_W-1:0]           s_tdata,  // [31:0] lookup_key
	input  wire logic [1:0]                           s_tuser,  // [0] opcode, [1] check_low
	// Result stream.
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [rcat_pkg::OUT_TDATA_W-1:0]          m_tdata,  // [6:0] entry_count,
	                                                            // [13:7] evicted, [15:14] 0
	output logic [rcat_pkg::STATUS_W-1:0]             m_tuser,  // [2:0] status
	// Configuration writes.
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [rcat_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [rcat_pkg::MARK_W-1:0]          cfg_data
);
	import rcat_pkg::*;

	rcat_cmd_t              cmd;
	rcat_sts_t              sts;
	rcat_status_t           res_status;
	logic [CNT_OUT_W-1:0]   res_count;
	logic [CNT_OUT_W-1:0]   res_evicted;
	logic [MARK_W-1:0]      high_mark_q;
	logic [MARK_W-1:0]      low_mark_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [STATUS_W-1:0]    m_tuser_q;
	logic                   out_free;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_mark_q <= HIGH_MARK_RST;
			low_mark_q  <= LOW_MARK_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_HIGH_MARK: high_mark_q <= cfg_data;
				CFG_LOW_MARK:  low_mark_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rcat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (s_tready)
	);

	rcat_datapath #(
		.CAPACITY (CAPACITY),
		.REF_BITS (REF_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_opcode   (s_tuser[0]),
		.in_key      (s_tdata),
		.in_check    (s_tuser[1]),
		.high_mark   (high_mark_q),
		.low_mark    (low_mark_q),
		.res_status  (res_status),
		.res_count   (res_count),
		.res_evicted (res_evicted)
	);

	// Output register: free when empty or its beat is taken this cycle.
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			m_tuser_q <= res_status;
			m_tdata_q <= {2'b00, res_evicted, res_count};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// A result is never loaded over a beat that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!m_tvalid_q || m_tready))
		else $error("result overwrote a pending beat");

	// Each loaded result shows up as a valid beat.
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_tvalid)
		else $error("loaded result not presented");

	// No item is accepted in the cycle right after another.
	a_accept_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("back-to-back accept");

endmodule

`default_nettype wire

/* tb/tb_refcount_aging_key_table.sv */
// Self-checking testbench for refcount_aging_key_table against a table predictor.
module tb_refcount_aging_key_table;
	timeunit 1ns;
	timeprecision 1ps;

	import rcat_pkg::*;

	localparam int CAPACITY    = 64;
	localparam int REF_BITS    = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE      = CAPACITY + 8;
	localparam int POOL_DEPTH  = 128;
	localparam int REPEAT_HITS = 24;
	localparam logic [REF_BITS-1:0] REFS_MAX = {REF_BITS{1'b1}};

	// One input beat and one result beat as seen by the predictor.
	typedef struct packed {
		logic             opcode;
		logic [KEY_W-1:0] lookup_key;
		logic             check_low;
	} key_item_t;

	typedef struct packed {
		rcat_status_t         status;
		logic [CNT_OUT_W-1:0] count;
		logic [CNT_OUT_W-1:0] evicted;
	} key_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [KEY_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic [STATUS_W-1:0] m_tuser;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	rcat_cfg_idx_t cfg_index = CFG_HIGH_MARK;
	logic [MARK_W-1:0] cfg_data = '0;

	// Handshake flags sampled at the rising edge, used at the falling edge.
	logic in_taken = 1'b0;
	logic cfg_fire = 1'b0;
	int unsigned items_taken = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;

	// Predictor state: table contents and watermark copies.
	bit tbl_valid [CAPACITY];
	bit [KEY_W-1:0] tbl_key [CAPACITY];
	bit [REF_BITS-1:0] tbl_refs [CAPACITY];
	int unsigned tbl_total = 0;
	bit [MARK_W-1:0] mark_hi = HIGH_MARK_RST;
	bit [MARK_W-1:0] mark_lo = LOW_MARK_RST;

	key_item_t pending_q [$];
	key_result_t expected_q [$];
	bit [KEY_W-1:0] key_pool [POOL_DEPTH];

	refcount_aging_key_table #(
		.CAPACITY(CAPACITY),
		.REF_BITS(REF_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Free-running clock, 10 ns period.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one beat to the table and returns the result it must produce.
	function automatic key_result_t table_step(key_item_t it);
		key_result_t r;
		int slot;
		int free_slot;
		int dropped;
		bit found;
		r.evicted = '0;
		if (it.opcode == OP_REF) begin
			found = 1'b0;
			free_slot = CAPACITY;
			for (slot = 0; slot < CAPACITY && !found; slot++) begin
				if (tbl_valid[slot] && tbl_key[slot] == it.lookup_key) begin
					found = 1'b1;
					if (tbl_refs[slot] != REFS_MAX)
						tbl_refs[slot] = tbl_refs[slot] + 1'b1;
				end else if (!tbl_valid[slot] && free_slot == CAPACITY) begin
					free_slot = slot;
				end
			end
			if (found) begin
				r.status = RES_HIT;
			end else if (tbl_total >= mark_hi || free_slot >= CAPACITY) begin
				r.status = RES_REJECTED;
			end else begin
				tbl_valid[free_slot] = 1'b1;
				tbl_key[free_slot] = it.lookup_key;
				tbl_refs[free_slot] = REF_BITS'(1);
				tbl_total++;
				r.status = RES_INSERTED;
			end
		end else if (it.check_low && tbl_total <= mark_lo) begin
			r.status = RES_SKIPPED;
		end else begin
			// Age every live entry; entries at one reference drop out.
			dropped = 0;
			for (slot = 0; slot < CAPACITY; slot++) begin
				if (tbl_valid[slot]) begin
					if (tbl_refs[slot] <= 1) begin
						tbl_valid[slot] = 1'b0;
						tbl_refs[slot] = '0;
						dropped++;
					end else begin
						tbl_refs[slot] = tbl_refs[slot] - 1'b1;
					end
				end
			end
			tbl_total = tbl_total - dropped;
			r.status = RES_CLEANED;
			r.evicted = dropped[CNT_OUT_W-1:0];
		end
		r.count = tbl_total[CNT_OUT_W-1:0];
		return r;
	endfunction

	task automatic note_mismatch(string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Sampling side: record handshakes, predict accepted beats, check result beats.
	always @(posedge clk) begin : sample
		key_item_t it;
		key_result_t want;
		in_taken <= s_tvalid && s_tready;
		cfg_fire <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_HIGH_MARK: mark_hi = cfg_data;
					CFG_LOW_MARK:  mark_lo = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_q.size() == 0) begin
					note_mismatch($sformatf("result %0d with none expected: status %0d",
						results_seen, m_tuser));
				end else begin
					want = expected_q.pop_front();
					if (m_tuser !== want.status)
						note_mismatch($sformatf("result %0d status: expected %0d, got %0d",
							results_seen, want.status, m_tuser));
					if (m_tdata[6:0] !== want.count)
						note_mismatch($sformatf("result %0d entry_count: expected %0d, got %0d",
							results_seen, want.count, m_tdata[6:0]));
					if (m_tdata[13:7] !== want.evicted)
						note_mismatch($sformatf("result %0d evicted: expected %0d, got %0d",
							results_seen, want.evicted, m_tdata[13:7]));
				end
			end
			if (s_tvalid && s_tready) begin
				it.opcode = s_tuser[0];
				it.lookup_key = s_tdata;
				it.check_low = s_tuser[1];
				expected_q.push_back(table_step(it));
				items_taken <= items_taken + 1;
			end
		end
	end

	// Sender: bursts of beats from the pending queue with random gaps between them.
	int unsigned burst_left = 1;
	int unsigned gap_left = 0;

	always @(negedge clk) begin : send
		key_item_t nxt;
		if (s_tvalid && !in_taken) begin
			// Current beat not taken yet; hold it.
		end else if (gap_left != 0) begin
			gap_left--;
			s_tvalid <= 1'b0;
		end else if (!arst_n || pending_q.size() == 0) begin
			s_tvalid <= 1'b0;
		end else begin
			nxt = pending_q.pop_front();
			s_tvalid <= 1'b1;
			s_tdata <= nxt.lookup_key;
			s_tuser <= {nxt.check_low, nxt.opcode};
			if (burst_left > 1) begin
				burst_left--;
			end else begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			end
		end
	end

	// Receiver: switches among stall patterns; twice holds off for a long stretch.
	int unsigned rx_hold_left = 0;
	int unsigned rx_holds_done = 0;
	int unsigned rx_mode = 0;
	int unsigned rx_mode_left = 0;
	int unsigned rx_phase = 0;

	always @(negedge clk) begin : receive
		logic ready_next;
		if (rx_hold_left != 0) begin
			rx_hold_left--;
			ready_next = 1'b0;
		end else if ((rx_holds_done == 0 && items_taken >= 150) ||
				(rx_holds_done == 1 && items_taken >= 1000)) begin
			rx_holds_done++;
			rx_hold_left = HOLD_CYCLES;
			ready_next = 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_mode_left = $urandom_range(20, 200);
			end
			rx_mode_left--;
			rx_phase++;
			case (rx_mode)
				0: ready_next = 1'b1;
				1: ready_next = 1'($urandom_range(0, 1));
				default: ready_next = (rx_phase % 5) < 2;
			endcase
		end
		m_tready <= ready_next;
	end

	function automatic key_item_t mk(logic op, logic [KEY_W-1:0] k, logic chk);
		key_item_t it;
		it.opcode = op;
		it.lookup_key = k;
		it.check_low = chk;
		return it;
	endfunction

	// Mostly references from a small key pool, some random keys, some cleans.
	function automatic key_item_t rand_item(int pool_n, int clean_pct);
		key_item_t it;
		it.lookup_key = $urandom;
		it.check_low = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < clean_pct) begin
			it.opcode = OP_CLEAN;
		end else begin
			it.opcode = OP_REF;
			if ($urandom_range(0, 19) != 0)
				it.lookup_key = key_pool[$urandom_range(0, pool_n - 1)];
		end
		return it;
	endfunction

	// Waits until every beat is sent and every result has come, then lets the block settle.
	task automatic wait_idle();
		do begin
			@(posedge clk);
			#1;
		end while (pending_q.size() != 0 || s_tvalid || expected_q.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(rcat_cfg_idx_t idx, logic [MARK_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(negedge clk); while (!cfg_fire);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [MARK_W-1:0] hi, logic [MARK_W-1:0] lo, int count,
			int pool_n, int clean_pct);
		int i;
		wait_idle();
		write_reg(CFG_HIGH_MARK, hi);
		write_reg(CFG_LOW_MARK, lo);
		for (i = 0; i < POOL_DEPTH; i++)
			key_pool[i] = $urandom;
		key_pool[$urandom_range(0, pool_n - 1)] = 32'h0000_0000;
		key_pool[$urandom_range(0, pool_n - 1)] = 32'hFFFF_FFFF;
		key_pool[$urandom_range(0, pool_n - 1)] = 32'h8000_0000;
		key_pool[$urandom_range(0, pool_n - 1)] = 32'h7FFF_FFFF;
		for (i = 0; i < count; i++)
			pending_q.push_back(rand_item(pool_n, clean_pct));
	endtask

	// Stimulus sequence and final verdict.
	initial begin : stim
		int i;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset watermarks: insert, checked clean skipped, unchecked clean evicts.
		pending_q.push_back(mk(OP_REF, 32'h0000_0000, 1'b0));
		pending_q.push_back(mk(OP_CLEAN, 32'hFFFF_FFFF, 1'b1));
		pending_q.push_back(mk(OP_CLEAN, 32'h0000_0000, 1'b0));
		wait_idle();

		// Tight marks: reject at the high mark, hit still counts there, low-mark skips.
		write_reg(CFG_HIGH_MARK, 7'd3);
		write_reg(CFG_LOW_MARK, 7'd1);
		pending_q.push_back(mk(OP_REF, 32'h0000_0000, 1'b0));
		pending_q.push_back(mk(OP_REF, 32'hFFFF_FFFF, 1'b0));
		pending_q.push_back(mk(OP_REF, 32'h8000_0000, 1'b0));
		pending_q.push_back(mk(OP_REF, 32'h7FFF_FFFF, 1'b0));
		pending_q.push_back(mk(OP_REF, 32'hFFFF_FFFF, 1'b0));
		pending_q.push_back(mk(OP_REF, 32'hAAAA_AAAA, 1'b1));
		pending_q.push_back(mk(OP_CLEAN, 32'h0000_0000, 1'b1));
		pending_q.push_back(mk(OP_CLEAN, 32'hFFFF_FFFF, 1'b1));
		pending_q.push_back(mk(OP_CLEAN, 32'h0000_0000, 1'b0));
		pending_q.push_back(mk(OP_CLEAN, 32'h5555_5555, 1'b0));
		pending_q.push_back(mk(OP_CLEAN, 32'h0000_0000, 1'b1));
		pending_q.push_back(mk(OP_REF, 32'h5555_5555, 1'b0));
		wait_idle();

		// High mark of zero: every miss rejected, hits still land.
		write_reg(CFG_HIGH_MARK, 7'd0);
		write_reg(CFG_LOW_MARK, 7'd0);
		pending_q.push_back(mk(OP_REF, 32'h1234_5678, 1'b0));
		pending_q.push_back(mk(OP_REF, 32'h5555_5555, 1'b0));
		pending_q.push_back(mk(OP_CLEAN, 32'h0000_0000, 1'b1));
		pending_q.push_back(mk(OP_CLEAN, 32'h0000_0000, 1'b1));
		pending_q.push_back(mk(OP_CLEAN, 32'h0000_0000, 1'b1));

		// Random phases across watermark settings, extremes included.
		run_phase(7'd64, 7'd32, 300, 48, 8);
		run_phase(7'd127, 7'd0, 300, 96, 3);
		run_phase(7'd1, 7'd0, 150, 4, 10);
		run_phase(7'd10, 7'd5, 250, 20, 10);
		run_phase(7'd64, 7'd64, 250, 70, 6);
		run_phase(7'd0, 7'd127, 100, 16, 10);
		run_phase(7'd127, 7'd20, 300, 80, 4);
		run_phase(7'd40, 7'd127, 200, 60, 8);

		// Empty the table so one key lands in the first slot, then hit it repeatedly.
		wait_idle();
		write_reg(CFG_HIGH_MARK, 7'd64);
		write_reg(CFG_LOW_MARK, 7'd0);
		while (tbl_total != 0) begin
			pending_q.push_back(mk(OP_CLEAN, 32'h0000_0000, 1'b0));
			wait_idle();
		end
		pending_q.push_back(mk(OP_REF, 32'hC3A5_5A3C, 1'b0));
		for (i = 0; i < REPEAT_HITS; i++)
			pending_q.push_back(mk(OP_REF, 32'hC3A5_5A3C, 1'b0));
		pending_q.push_back(mk(OP_CLEAN, 32'h0000_0000, 1'b0));
		pending_q.push_back(mk(OP_REF, 32'hC3A5_5A3C, 1'b0));
		pending_q.push_back(mk(OP_CLEAN, 32'h0000_0000, 1'b1));
		wait_idle();

		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Guard against a hung run.
	initial begin : watchdog
		#40_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

/* sim.f */
rtl/rcat_pkg.sv
rtl/rcat_ctrl.sv
rtl/rcat_datapath.sv
rtl/refcount_aging_key_table.sv
tb/tb_refcount_aging_key_table.sv
